[src/text_signalling_header_parser_core_defines.svh]
// Assertion macros for the text signalling header parser core.
// Included by RTL files that carry concurrent assertions.
`ifndef TEXT_SIGNALLING_HEADER_PARSER_CORE_DEFINES_SVH
`define TEXT_SIGNALLING_HEADER_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TSHP_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define TSHP_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define TSHP_ASSERT_IMPL(label, clk, rst, prop)
`define TSHP_ASSERT_NORST(label, clk, prop)
`endif
`endif

[src/tshp_pkg.sv]
// Shared types and constants of the text signalling header parser.
// No dependencies.
package tshp_pkg;

   typedef enum logic [4:0] {
      PH_START, PH_REASON, PH_REASON_LF, PH_USER, PH_HOST, PH_HOST_LF, PH_LINE,
      PH_NAME, PH_COLON_SP, PH_BODY, PH_NUM, PH_CSEQ_METH, PH_MEDIA_HOST,
      PH_MEDIA_PORT, PH_SKIP, PH_SKIP_LF, PH_DONE, PH_FAIL
   } phase_type;

   typedef enum logic [2:0] {
      K_CALLID, K_CSEQ, K_MEDIA, K_FROM, K_EVENT, K_LENGTH, K_AGENT, K_NONE
   } kind_type;

   localparam logic [3:0] TAG_NONE   = 4'd0;
   localparam logic [3:0] TAG_METHOD = 4'd1;
   localparam logic [3:0] TAG_USER   = 4'd2;
   localparam logic [3:0] TAG_HOST   = 4'd3;
   localparam logic [3:0] TAG_REASON = 4'd4;
   localparam logic [3:0] TAG_CALLID = 4'd5;
   localparam logic [3:0] TAG_CSEQM  = 4'd6;
   localparam logic [3:0] TAG_EVENT  = 4'd7;
   localparam logic [3:0] TAG_FROM   = 4'd8;
   localparam logic [3:0] TAG_MEDIA  = 4'd9;
   localparam logic [3:0] TAG_AGENT  = 4'd10;

   localparam logic [2:0] REG_METHOD = 3'd0;
   localparam logic [2:0] REG_USER   = 3'd1;
   localparam logic [2:0] REG_HOST   = 3'd2;
   localparam logic [2:0] REG_REASON = 3'd3;
   localparam logic [2:0] REG_ID     = 3'd4;
   localparam logic [2:0] REG_EVENT  = 3'd5;
   localparam logic [2:0] REG_PORT   = 3'd6;
   localparam logic [2:0] REG_TEXT   = 3'd7;

   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SP    = 8'd32;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_AT    = 8'd64;
   localparam logic [7:0] CSEQ_DIGITS_LIMIT   = 8'd11;
   localparam logic [7:0] LENGTH_DIGITS_LIMIT = 8'd5;

   typedef struct packed {
      logic [7:0] method_lim;
      logic [7:0] user_lim;
      logic [7:0] host_lim;
      logic [7:0] reason_lim;
      logic [7:0] id_lim;
      logic [7:0] event_lim;
      logic [3:0] port_lim;
      logic [7:0] text_lim;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  tag;
      logic [7:0]  data;
      logic        done;
      logic        ok;
      logic [3:0]  mclass;
      logic [9:0]  status;
      logic [31:0] seq;
      logic [13:0] length;
      logic [15:0] port;
      logic [8:0]  hmap;
   } result_type;

   function automatic logic [7:0] lc(input logic [7:0] b);
      lc = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
   endfunction

   function automatic logic is_dig(input logic [7:0] b);
      is_dig = (b >= 8'd48 && b <= 8'd57);
   endfunction

   // lower-case character of a known header name at a position, 0 past the end
   function automatic logic [7:0] hdr_char(input logic [2:0] k, input logic [3:0] p);
      logic [8*14-1:0] s;
      logic [3:0] n;
      unique case (k)
         3'd0: begin s = {"call-id", 56'd0}; n = 4'd7; end
         3'd1: begin s = {"cseq", 80'd0}; n = 4'd4; end
         3'd2: begin s = {"media", 72'd0}; n = 4'd5; end
         3'd3: begin s = {"from", 80'd0}; n = 4'd4; end
         3'd4: begin s = {"event", 72'd0}; n = 4'd5; end
         3'd5: begin s = "content-length"; n = 4'd14; end
         3'd6: begin s = {"user-agent", 32'd0}; n = 4'd10; end
         default: begin s = '0; n = 4'd0; end
      endcase
      hdr_char = (p < n) ? s[8*(13 - p) +: 8] : 8'd0;
   endfunction

   function automatic logic [3:0] hdr_len(input logic [2:0] k);
      unique case (k)
         3'd0: hdr_len = 4'd7;
         3'd1: hdr_len = 4'd4;
         3'd2: hdr_len = 4'd5;
         3'd3: hdr_len = 4'd4;
         3'd4: hdr_len = 4'd5;
         3'd5: hdr_len = 4'd14;
         3'd6: hdr_len = 4'd10;
         default: hdr_len = 4'd0;
      endcase
   endfunction

   function automatic logic [7:0] meth_char(input logic [1:0] k, input logic [2:0] p);
      logic [8*7-1:0] s;
      logic [2:0] n;
      unique case (k)
         2'd0: begin s = {"conn", 24'd0}; n = 3'd4; end
         2'd1: begin s = "disconn"; n = 3'd7; end
         2'd2: begin s = {"reset", 16'd0}; n = 3'd5; end
         default: begin s = {"notify", 8'd0}; n = 3'd6; end
      endcase
      meth_char = (p < n) ? s[8*(6 - p) +: 8] : 8'd0;
   endfunction

   function automatic logic [2:0] meth_len(input logic [1:0] k);
      unique case (k)
         2'd0: meth_len = 3'd4;
         2'd1: meth_len = 3'd7;
         2'd2: meth_len = 3'd5;
         default: meth_len = 3'd6;
      endcase
   endfunction

endpackage

[src/text_signalling_header_parser_core.sv]
// Text signalling header parser, one byte per item, one result per item.
// Result valid the cycle after acceptance; one item per cycle unless the output stalls.
// Throughput is set by the single parse-step register stage and a one-entry output register
// that is refilled in the same cycle it is taken.
// Synchronous active-high reset restores default limits and the start-of-message state.
`include "text_signalling_header_parser_core_defines.svh"
module text_signalling_header_parser_core #(
   parameter int NAME_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_field_tag,
   output logic [7:0]  rsp_field_byte,
   output logic        rsp_done_res,
   output logic        rsp_parse_ok,
   output logic [3:0]  rsp_message_class,
   output logic [9:0]  rsp_status_code,
   output logic [31:0] rsp_sequence_number,
   output logic [13:0] rsp_content_length,
   output logic [15:0] rsp_media_port,
   output logic [8:0]  rsp_present_map,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import tshp_pkg::*;

   cfg_type    cfg;
   result_type next_res;
   result_type res_ff;
   logic       valid_ff;
   logic       step;

   tshp_cfg_regs u_cfg (
      .clock, .reset, .csr_write_enable,
      .csr_index(csr_index[2:0]), .csr_index_valid(!csr_index[3]),
      .csr_write_data, .cfg
   );

   tshp_parse #(.NAME_MAX(NAME_MAX)) u_parse (
      .clock, .reset, .step,
      .data_byte(req_data_byte), .end_of_message(req_end_of_message),
      .cfg, .result(next_res)
   );

   // accept whenever the output register is empty or being drained
   assign req_ready = !valid_ff || rsp_ready;
   assign step = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (req_ready) valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (step) res_ff <= next_res;
   end

   assign rsp_valid = valid_ff;
   assign rsp_field_tag = res_ff.tag;
   assign rsp_field_byte = res_ff.data;
   assign rsp_done_res = res_ff.done;
   assign rsp_parse_ok = res_ff.ok;
   assign rsp_message_class = res_ff.mclass;
   assign rsp_status_code = res_ff.status;
   assign rsp_sequence_number = res_ff.seq;
   assign rsp_content_length = res_ff.length;
   assign rsp_media_port = res_ff.port;
   assign rsp_present_map = res_ff.hmap;

   `TSHP_ASSERT_IMPL(a_out_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_field_byte)))
   `TSHP_ASSERT_IMPL(a_no_verdict_unless_done, clock, reset,
      (rsp_valid && !rsp_done_res) |-> (rsp_present_map == 9'd0 && !rsp_parse_ok))
   `TSHP_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)
endmodule

[src/tshp_cfg_regs.sv]
// Configuration registers of the text signalling header parser.
// Depends on tshp_pkg.
module tshp_cfg_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic              csr_index_valid,
   input  logic [7:0]        csr_write_data,
   output tshp_pkg::cfg_type cfg
);
   import tshp_pkg::*;

   cfg_type cfg_ff;

   // write one register; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{method_lim: 8'd16, user_lim: 8'd32, host_lim: 8'd64,
                     reason_lim: 8'd64, id_lim: 8'd64, event_lim: 8'd32,
                     port_lim: 4'd6, text_lim: 8'd128};
      end else if (csr_write_enable && csr_index_valid) begin
         unique case (csr_index)
            REG_METHOD: cfg_ff.method_lim <= csr_write_data;
            REG_USER:   cfg_ff.user_lim   <= csr_write_data;
            REG_HOST:   cfg_ff.host_lim   <= csr_write_data;
            REG_REASON: cfg_ff.reason_lim <= csr_write_data;
            REG_ID:     cfg_ff.id_lim     <= csr_write_data;
            REG_EVENT:  cfg_ff.event_lim  <= csr_write_data;
            REG_PORT:   cfg_ff.port_lim   <= csr_write_data[3:0];
            default:    cfg_ff.text_lim   <= csr_write_data;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

[src/tshp_parse.sv]
// Per-byte parse step: message state and next-result logic.
// Depends on tshp_pkg and the assertion macro header.
`include "text_signalling_header_parser_core_defines.svh"
module tshp_parse #(
   parameter int NAME_MAX = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_message,
   input  tshp_pkg::cfg_type    cfg,
   output tshp_pkg::result_type result
);
   import tshp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [6:0]  nflags_ff, nflags_in;
   logic [3:0]  mflags_ff, mflags_in;
   logic [31:0] acc_ff, acc_in;
   logic [9:0]  status_ff, status_in;
   logic [31:0] seq_ff, seq_in;
   logic [13:0] len_ff, len_in;
   logic [15:0] port_ff, port_in;
   logic [8:0]  hmap_ff, hmap_in;
   logic        verdict_ff, verdict_in;
   logic        digits_ff, digits_in;
   kind_type    kind_ff, kind_in;
   logic [1:0]  nmode_ff, nmode_in;
   logic [3:0]  class_ff, class_in;

   result_type  res;
   logic        term;
   logic [7:0]  b, lb;
   logic [8:0]  hbit;
   logic [31:0] acc_x10;
   logic [9:0]  st_mod;
   logic [3:0]  hund;
   logic [7:0]  ncount;
   logic [2:0]  nk;
   logic        nk_hit;
   logic [2:0]  mk;
   logic        mk_hit;
   logic [6:0]  nf_base;
   logic [7:0]  blim;
   logic [3:0]  btag;
   phase_type   bph;
   logic        do_body;

   assign b = data_byte;
   assign lb = lc(b);
   assign term = end_of_message || (b == 8'd0);
   assign hbit = 9'd1 << ({1'b0, kind_in} + 4'd2);
   assign acc_x10 = (acc_ff << 3) + (acc_ff << 1);

   // status code: low three decimal digits of at most three accumulated digits
   assign st_mod = acc_ff[9:0];
   always_comb begin
      if (st_mod >= 10'd900) hund = 4'd9;
      else if (st_mod >= 10'd800) hund = 4'd8;
      else if (st_mod >= 10'd700) hund = 4'd7;
      else if (st_mod >= 10'd600) hund = 4'd6;
      else if (st_mod >= 10'd500) hund = 4'd5;
      else if (st_mod >= 10'd400) hund = 4'd4;
      else if (st_mod >= 10'd300) hund = 4'd3;
      else if (st_mod >= 10'd200) hund = 4'd2;
      else if (st_mod >= 10'd100) hund = 4'd1;
      else hund = 4'd0;
   end

   // name flags used by a name byte: fresh at the start of a header line
   assign nf_base = (phase_ff == PH_LINE) ? 7'h7F : nflags_ff;
   // name length seen by a delimiter byte
   assign ncount = (phase_ff == PH_LINE) ? 8'd0 : count_ff;

   // first live candidate whose length equals the count
   always_comb begin
      nk = 3'd7;
      nk_hit = 1'b0;
      for (int i = 6; i >= 0; i--) begin
         if (nf_base[i] && ncount == {4'd0, hdr_len(3'(i))}) begin
            nk = 3'(i);
            nk_hit = 1'b1;
         end
      end
      mk = 3'd0;
      mk_hit = 1'b0;
      for (int i = 3; i >= 0; i--) begin
         if (mflags_ff[i] && count_ff == {5'd0, meth_len(2'(i))}) begin
            mk = 3'(i);
            mk_hit = 1'b1;
         end
      end
   end

   // main step
   always_comb begin
      phase_in = phase_ff; count_in = count_ff; nflags_in = nflags_ff;
      mflags_in = mflags_ff; acc_in = acc_ff; status_in = status_ff;
      seq_in = seq_ff; len_in = len_ff; port_in = port_ff; hmap_in = hmap_ff;
      verdict_in = verdict_ff; digits_in = digits_ff; kind_in = kind_ff;
      nmode_in = nmode_ff; class_in = class_ff;
      res = '0;
      res.data = b;
      blim = 8'd0; btag = TAG_NONE; bph = phase_ff; do_body = 1'b0;
      if (term) begin
         res.done = 1'b1;
         res.ok = (phase_ff == PH_DONE) || (phase_ff == PH_LINE);
         res.mclass = class_ff; res.status = status_ff; res.seq = seq_ff;
         res.length = len_ff; res.port = port_ff; res.hmap = hmap_ff;
         phase_in = PH_START; count_in = '0; nflags_in = 7'h7F; mflags_in = 4'hF;
         acc_in = '0; status_in = '0; seq_in = '0; len_in = '0; port_in = '0;
         hmap_in = '0; verdict_in = 1'b0; digits_in = 1'b1; kind_in = K_NONE;
         nmode_in = 2'd0; class_in = '0;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (count_ff == 8'd3 && digits_ff && b == CH_SP) begin
                  status_in = st_mod;
                  class_in = (hund >= 4'd1 && hund <= 4'd6) ? hund + 4'd4 : 4'd11;
                  hmap_in = hmap_ff | 9'd2;
                  phase_in = PH_REASON; count_in = '0;
               end else if (b == CH_SP) begin
                  if (count_ff >= cfg.method_lim) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else begin
                     class_in = mk_hit ? {1'b0, mk} + 4'd1 : 4'd0;
                     phase_in = PH_USER; count_in = '0;
                  end
               end else if (count_ff >= cfg.method_lim &&
                            !(digits_ff && count_ff < 8'd3 && is_dig(b))) begin
                  phase_in = PH_FAIL; verdict_in = 1'b1;
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     if (!(count_ff < {5'd0, meth_len(2'(i))} &&
                           lb == meth_char(2'(i), count_ff[2:0])))
                        mflags_in[i] = 1'b0;
                  end
                  if (is_dig(b)) acc_in = acc_x10 + {28'd0, b[3:0]};
                  else digits_in = 1'b0;
                  count_in = count_ff + 8'd1;
                  res.tag = TAG_METHOD;
               end
            end
            PH_REASON: begin
               if (count_ff >= cfg.reason_lim) begin
                  phase_in = PH_FAIL; verdict_in = 1'b1;
               end else if (b == CH_CR) begin
                  phase_in = PH_REASON_LF; count_in = '0;
               end else begin
                  count_in = count_ff + 8'd1; res.tag = TAG_REASON;
               end
            end
            PH_REASON_LF: begin
               if (b == CH_LF) phase_in = PH_LINE;
               else begin
                  phase_in = PH_FAIL; verdict_in = 1'b1;
               end
            end
            PH_USER: begin
               if (count_ff >= cfg.user_lim) begin
                  phase_in = PH_FAIL; verdict_in = 1'b1;
               end else if (b == CH_AT) begin
                  phase_in = PH_HOST; count_in = '0;
               end else begin
                  count_in = count_ff + 8'd1; res.tag = TAG_USER;
               end
            end
            PH_HOST: begin
               if (count_ff >= cfg.host_lim) begin
                  phase_in = PH_FAIL; verdict_in = 1'b1;
               end else if (b == CH_CR) begin
                  phase_in = PH_HOST_LF; count_in = '0;
               end else begin
                  count_in = count_ff + 8'd1; res.tag = TAG_HOST;
               end
            end
            PH_HOST_LF: begin
               hmap_in = hmap_ff | 9'd1; phase_in = PH_LINE;
            end
            PH_LINE, PH_NAME: begin
               if (phase_ff == PH_LINE && b == CH_CR) begin
                  phase_in = PH_DONE; verdict_in = 1'b1;
               end else begin
                  count_in = ncount;
                  nflags_in = nf_base;
                  if (count_in >= 8'(NAME_MAX)) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else if (b == CH_COLON || b == CH_SP) begin
                     if (!nk_hit) phase_in = PH_SKIP;
                     else if (b == CH_COLON) begin
                        kind_in = kind_type'(nk); phase_in = PH_COLON_SP;
                     end else begin
                        phase_in = PH_FAIL; verdict_in = 1'b1;
                     end
                  end else begin
                     for (int i = 0; i < 7; i++) begin
                        if (!(count_in < {4'd0, hdr_len(3'(i))} &&
                              lb == hdr_char(3'(i), count_in[3:0])))
                           nflags_in[i] = 1'b0;
                     end
                     count_in = count_in + 8'd1;
                     phase_in = PH_NAME;
                  end
               end
            end
            PH_COLON_SP, PH_BODY, PH_NUM, PH_CSEQ_METH, PH_MEDIA_HOST,
            PH_MEDIA_PORT: begin
               bph = phase_ff;
               do_body = 1'b1;
               if (phase_ff == PH_COLON_SP) begin
                  count_in = '0; acc_in = '0; nmode_in = 2'd0;
                  if (kind_ff == K_CSEQ || kind_ff == K_LENGTH) bph = PH_NUM;
                  else if (kind_ff == K_MEDIA) bph = PH_MEDIA_HOST;
                  else bph = PH_BODY;
                  phase_in = bph;
                  do_body = (b != CH_SP);
               end
            end
            PH_SKIP: if (b == CH_CR) phase_in = PH_SKIP_LF;
            PH_SKIP_LF: phase_in = PH_LINE;
            default: ;
         endcase

         // body of a header line; count and accumulator come from above
         if (do_body) begin
            unique case (bph)
               PH_BODY: begin
                  if (kind_in == K_CALLID) begin blim = cfg.id_lim; btag = TAG_CALLID; end
                  else if (kind_in == K_FROM) begin blim = cfg.user_lim; btag = TAG_FROM; end
                  else if (kind_in == K_EVENT) begin blim = cfg.event_lim; btag = TAG_EVENT; end
                  else begin blim = cfg.text_lim; btag = TAG_AGENT; end
                  if (count_in >= blim) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else if (b == CH_CR) begin
                     hmap_in = hmap_ff | hbit; phase_in = PH_SKIP_LF;
                  end else begin
                     count_in = count_in + 8'd1; res.tag = btag;
                  end
               end
               PH_NUM: begin
                  if (kind_in == K_CSEQ && count_in >= CSEQ_DIGITS_LIMIT) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else if (kind_in == K_CSEQ && b == CH_SP) begin
                     seq_in = acc_in; phase_in = PH_CSEQ_METH; count_in = '0;
                  end else if (kind_in != K_CSEQ && count_in >= LENGTH_DIGITS_LIMIT) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else if (kind_in != K_CSEQ && b == CH_CR) begin
                     len_in = acc_in[13:0]; hmap_in = hmap_ff | hbit;
                     phase_in = PH_SKIP_LF;
                  end else begin
                     if (!(nmode_in == 2'd0 && b == CH_SP)) begin
                        if (nmode_in < 2'd2 && is_dig(b)) begin
                           acc_in = (acc_in << 3) + (acc_in << 1) + {28'd0, b[3:0]};
                           nmode_in = 2'd1;
                        end else nmode_in = 2'd2;
                     end
                     count_in = count_in + 8'd1;
                  end
               end
               PH_CSEQ_METH: begin
                  if (count_in >= cfg.method_lim) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else if (b == CH_CR) begin
                     hmap_in = hmap_ff | hbit; phase_in = PH_SKIP_LF;
                  end else begin
                     count_in = count_in + 8'd1; res.tag = TAG_CSEQM;
                  end
               end
               PH_MEDIA_HOST: begin
                  if (count_in >= cfg.host_lim) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else if (b == CH_COLON) begin
                     phase_in = PH_MEDIA_PORT; count_in = '0; acc_in = '0;
                     nmode_in = 2'd0;
                  end else begin
                     count_in = count_in + 8'd1; res.tag = TAG_MEDIA;
                  end
               end
               default: begin
                  if (count_in >= {4'd0, cfg.port_lim}) begin
                     phase_in = PH_FAIL; verdict_in = 1'b1;
                  end else if (b == CH_CR) begin
                     port_in = acc_in[15:0]; hmap_in = hmap_ff | hbit;
                     phase_in = PH_SKIP_LF;
                  end else begin
                     if (!(nmode_in == 2'd0 && b == CH_SP)) begin
                        if (nmode_in < 2'd2 && is_dig(b)) begin
                           acc_in = (acc_in << 3) + (acc_in << 1) + {28'd0, b[3:0]};
                           nmode_in = 2'd1;
                        end else nmode_in = 2'd2;
                     end
                     count_in = count_in + 8'd1;
                  end
               end
            endcase
         end
      end
   end

   // advance message state on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START; count_ff <= '0; nflags_ff <= 7'h7F; mflags_ff <= 4'hF;
         acc_ff <= '0; status_ff <= '0; seq_ff <= '0; len_ff <= '0; port_ff <= '0;
         hmap_ff <= '0; verdict_ff <= 1'b0; digits_ff <= 1'b1; kind_ff <= K_NONE;
         nmode_ff <= 2'd0; class_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; count_ff <= count_in; nflags_ff <= nflags_in;
         mflags_ff <= mflags_in; acc_ff <= acc_in; status_ff <= status_in;
         seq_ff <= seq_in; len_ff <= len_in; port_ff <= port_in; hmap_ff <= hmap_in;
         verdict_ff <= verdict_in; digits_ff <= digits_in; kind_ff <= kind_in;
         nmode_ff <= nmode_in; class_ff <= class_in;
      end
   end

   assign result = res;

   `TSHP_ASSERT_IMPL(a_fail_sets_verdict, clock, reset, (phase_ff == PH_FAIL) |-> verdict_ff)
   `TSHP_ASSERT_IMPL(a_done_sets_verdict, clock, reset, (phase_ff == PH_DONE) |-> verdict_ff)
   `TSHP_ASSERT_IMPL(a_term_restarts, clock, reset,
      (step && term) |=> (phase_ff == PH_START && hmap_ff == 9'd0))
   `TSHP_ASSERT_IMPL(a_status_has_bit, clock, reset,
      (class_ff >= 4'd5) |-> hmap_ff[1])
endmodule
